@@ hw/rtl/ibdl_pkg.sv @@
// ============================================================================
// Double-booking calendar package
// Shared widths, status codes and beat types for the calendar block.
// ============================================================================
package ibdl_pkg;

   localparam int MaxBookings = 64;
   localparam int MaxDoubles  = 64;
   localparam int TimeBits    = 32;
   localparam int CntBits     = $clog2(MaxBookings + 1);
   localparam int DblCntBits  = $clog2(MaxDoubles + 1);
   // Both rings are built with the same number of cells.
   localparam int RingCells   = (MaxBookings > MaxDoubles) ? MaxBookings : MaxDoubles;

   localparam logic [1:0] ST_OK     = 2'd0;
   localparam logic [1:0] ST_TRIPLE = 2'd1;
   localparam logic [1:0] ST_FULL   = 2'd2;
   localparam logic [1:0] ST_EMPTY  = 2'd3;

   typedef struct packed {
      logic [31:0] range_start;
      logic [31:0] range_end;
   } req_type;

   typedef struct packed {
      logic [1:0] status;
      logic       accepted;
   } rsp_type;

   // One interval travelling along the chain.
   typedef struct packed {
      logic                valid;
      logic [TimeBits-1:0] lo;
      logic [TimeBits-1:0] hi;
   } ival_type;

   function automatic logic overlaps(input logic [TimeBits-1:0] s1,
                                     input logic [TimeBits-1:0] e1,
                                     input logic [TimeBits-1:0] s2,
                                     input logic [TimeBits-1:0] e2);
      return (s1 < e2) && (s2 < e1);
   endfunction

endpackage

@@ hw/rtl/ibdl_cell.sv @@
// ============================================================================
// Calendar storage cell
// Holds one interval and passes the stored interval to its neighbor each
// cycle while the table rotates, so the controller sees one entry a cycle.
// ============================================================================
module ibdl_cell (
   input  logic               clock,
   input  logic               reset,
   input  logic               rotate,
   input  ibdl_pkg::ival_type d_in,
   output ibdl_pkg::ival_type q_out
);
   import ibdl_pkg::*;

   ival_type data_ff;

   // Shift the ring by one place when asked; reset empties the cell.
   always_ff @(posedge clock) begin
      if (reset) begin
         data_ff.valid <= 1'b0;
      end else if (rotate) begin
         data_ff <= d_in;
      end
   end

   assign q_out = data_ff;

endmodule

@@ hw/rtl/ibdl_ring.sv @@
// ============================================================================
// Calendar ring
// A circular chain of storage cells. Rotating moves every entry one place;
// after a full turn the table is back in place. A new entry enters at the
// head by replacing the beat that comes round at the tail.
// ============================================================================
module ibdl_ring (
   input  logic               clock,
   input  logic               reset,
   input  logic               rotate,
   input  logic               replace,
   input  ibdl_pkg::ival_type new_val,
   output ibdl_pkg::ival_type tail
);
   import ibdl_pkg::*;

   ival_type link [RingCells+1];

   // Feed the tail back into the head, or a new entry in its place.
   assign link[0] = replace ? new_val : link[RingCells];
   assign tail    = link[RingCells];

   for (genvar g = 0; g < RingCells; g++) begin : g_cell
      ibdl_cell u_cell (
         .clock (clock),
         .reset (reset),
         .rotate(rotate),
         .d_in  (link[g]),
         .q_out (link[g+1])
      );
   end

endmodule

@@ hw/rtl/interval_booking_double_limit_top.sv @@
// An accepted booking turns the double ring once and the single ring twice
// before it is stored and answered; a triple overlap is answered after the
// double-ring turn, a full table after the counting turn, and an empty range
// without a turn of either ring. A new request is taken only while the
// sequencer is idle, so one booking is in progress at a time.
// Reset clears the counts, the cell valid bits and control; the result register
// lets the next request enter while a result waits.
// ============================================================================
// Double-booking calendar top level
// Checks a request against the double ring, then counts and appends overlaps
// while walking the single ring, and finally stores an accepted request.
// ============================================================================
module interval_booking_double_limit_top (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  ibdl_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output ibdl_pkg::rsp_type rsp_data
);
   import ibdl_pkg::*;

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_CHECK = 3'd1;
   localparam logic [2:0] S_COUNT = 3'd2;
   localparam logic [2:0] S_FILL  = 3'd3;
   localparam logic [2:0] S_DONE  = 3'd4;

   localparam int StepBits = $clog2(RingCells + 1);

   logic [2:0]            state_ff, state_in;
   logic [StepBits-1:0]   step_ff, step_in;
   logic [CntBits-1:0]    scount_ff, scount_in;
   logic [DblCntBits-1:0] dcount_ff, dcount_in;
   logic [DblCntBits:0]   need_ff, need_in;
   logic [TimeBits-1:0]   s_ff, s_in, e_ff, e_in;
   logic                  hit_ff, hit_in;
   logic [1:0]            status_ff, status_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   rsp_type               rsp_ff, rsp_in;

   logic     s_rot, s_rep, d_rot, d_rep;
   ival_type s_new, d_new, s_tail, d_tail;

   ibdl_ring u_single (
      .clock(clock), .reset(reset), .rotate(s_rot), .replace(s_rep), .new_val(s_new),
      .tail(s_tail)
   );
   ibdl_ring u_double (
      .clock(clock), .reset(reset), .rotate(d_rot), .replace(d_rep), .new_val(d_new),
      .tail(d_tail)
   );

   logic take, done_free, s_hit, d_hit;
   assign done_free = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != S_IDLE);
   assign take      = req_valid && !req_stall;
   assign s_hit     = s_tail.valid && overlaps(s_ff, e_ff, s_tail.lo, s_tail.hi);
   assign d_hit     = d_tail.valid && overlaps(s_ff, e_ff, d_tail.lo, d_tail.hi);

   // Sequencer: the check, count and fill phases each turn a ring once.
   always_comb begin
      state_in     = state_ff;
      step_in      = step_ff;
      scount_in    = scount_ff;
      dcount_in    = dcount_ff;
      need_in      = need_ff;
      s_in         = s_ff;
      e_in         = e_ff;
      hit_in       = hit_ff;
      status_in    = status_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_in       = rsp_ff;
      s_rot = 1'b0; s_rep = 1'b0; d_rot = 1'b0; d_rep = 1'b0;
      s_new = '{valid: 1'b1, lo: s_ff, hi: e_ff};
      d_new = '{valid: 1'b1, lo: (s_ff > s_tail.lo) ? s_ff : s_tail.lo,
                hi: (e_ff < s_tail.hi) ? e_ff : s_tail.hi};
      unique case (state_ff)
         S_IDLE: begin
            if (take) begin
               s_in     = req_data.range_start[TimeBits-1:0];
               e_in     = req_data.range_end[TimeBits-1:0];
               step_in  = '0;
               hit_in   = 1'b0;
               need_in  = '0;
               if (!(req_data.range_start < req_data.range_end)) begin
                  status_in = ST_EMPTY;
                  state_in  = S_DONE;
               end else begin
                  status_in = ST_OK;
                  state_in  = S_CHECK;
               end
            end
         end
         S_CHECK: begin
            // Walk the double ring; entries past the count are not valid.
            d_rot = 1'b1;
            if (d_hit) hit_in = 1'b1;
            step_in = step_ff + 1'b1;
            if (step_ff == StepBits'(RingCells - 1)) begin
               step_in  = '0;
               state_in = (hit_ff || d_hit) ? S_DONE : S_COUNT;
               if (hit_ff || d_hit) status_in = ST_TRIPLE;
            end
         end
         S_COUNT: begin
            s_rot = 1'b1;
            if (s_hit) need_in = need_ff + 1'b1;
            step_in = step_ff + 1'b1;
            if (step_ff == StepBits'(RingCells - 1)) begin
               step_in = '0;
               if ((scount_ff >= CntBits'(MaxBookings)) ||
                   ((DblCntBits+1)'(dcount_ff) + need_in > (DblCntBits+1)'(MaxDoubles))) begin
                  status_in = ST_FULL;
                  state_in  = S_DONE;
               end else begin
                  state_in = S_FILL;
               end
            end
         end
         S_FILL: begin
            // Second turn: drop intersections into the double ring, then append.
            s_rot = 1'b1;
            if (s_hit) begin
               d_rot     = 1'b1;
               d_rep     = 1'b1;
               dcount_in = dcount_ff + 1'b1;
            end
            step_in = step_ff + 1'b1;
            if (step_ff == StepBits'(RingCells - 1)) begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (status_ff == ST_OK && step_ff != '0) begin
               // Store the request at the head of the single ring.
               s_rot     = 1'b1;
               s_rep     = 1'b1;
               scount_in = scount_ff + 1'b1;
               step_in   = '0;
            end else if (done_free) begin
               rsp_valid_in = 1'b1;
               rsp_in       = '{status: status_ff, accepted: status_ff == ST_OK};
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         step_ff      <= '0;
         scount_ff    <= '0;
         dcount_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         scount_ff    <= scount_in;
         dcount_ff    <= dcount_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      need_ff   <= need_in;
      s_ff      <= s_in;
      e_ff      <= e_in;
      hit_ff    <= hit_in;
      status_ff <= status_in;
      rsp_ff    <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // Checks on the sequencer.
   a_idle_only: assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_IDLE) |-> req_stall) else $error("request taken while busy");
   a_acc_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.accepted == (rsp_data.status == ST_OK)))
      else $error("accepted flag mismatch");
   a_cnt: assert property (@(posedge clock) disable iff (reset)
      scount_ff <= CntBits'(MaxBookings)) else $error("booking count overflow");
   a_dcnt: assert property (@(posedge clock) disable iff (reset)
      dcount_ff <= DblCntBits'(MaxDoubles)) else $error("double count overflow");

endmodule

@@ tb/testbench.sv @@
`timescale 1ns / 1ps
// ============================================================================
// Double-booking calendar testbench
// Drives booking requests in bursts with random gaps, stalls the result side
// on its own pattern, and checks every result beat against a local model of
// the booking and overlap tables.
// ============================================================================
module testbench;
   import ibdl_pkg::*;

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_stall;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_stall;
   rsp_type rsp_data;

   interval_booking_double_limit_top DUT (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data)
   );

   // Model of the calendar tables.
   logic [31:0] book_lo [MaxBookings];
   logic [31:0] book_hi [MaxBookings];
   int          book_cnt;
   logic [31:0] dbl_lo [MaxDoubles];
   logic [31:0] dbl_hi [MaxDoubles];
   int          dbl_cnt;

   req_type pending_reqs[$];
   rsp_type expected_rsps[$];
   int      errors;
   int      hold_cycles;
   bit      pause_req;
   bit      req_took;

   function automatic void queue_req(req_type r);
      pending_reqs.insert(pending_reqs.size(), r);
   endfunction

   function automatic void queue_rsp(rsp_type r);
      expected_rsps.insert(expected_rsps.size(), r);
   endfunction

   function automatic bit hits(logic [31:0] s1, logic [31:0] e1,
                               logic [31:0] s2, logic [31:0] e2);
      return (s1 < e2) && (s2 < e1);
   endfunction

   // Computes the answer to one booking and updates the model tables.
   function automatic rsp_type book_interval(req_type r);
      rsp_type     o;
      logic [1:0]  st;
      int          need;
      logic [31:0] s;
      logic [31:0] e;
      s = r.range_start;
      e = r.range_end;
      st = ST_OK;
      need = 0;
      if (!(s < e)) begin
         st = ST_EMPTY;
      end else begin
         for (int i = 0; i < dbl_cnt; i++)
            if (st == ST_OK && hits(s, e, dbl_lo[i], dbl_hi[i])) st = ST_TRIPLE;
         if (st == ST_OK) begin
            for (int i = 0; i < book_cnt; i++)
               if (hits(s, e, book_lo[i], book_hi[i])) need++;
            if (book_cnt >= MaxBookings || dbl_cnt + need > MaxDoubles) st = ST_FULL;
         end
         if (st == ST_OK) begin
            for (int i = 0; i < book_cnt; i++) begin
               if (hits(s, e, book_lo[i], book_hi[i])) begin
                  dbl_lo[dbl_cnt] = (s > book_lo[i]) ? s : book_lo[i];
                  dbl_hi[dbl_cnt] = (e < book_hi[i]) ? e : book_hi[i];
                  dbl_cnt++;
               end
            end
            book_lo[book_cnt] = s;
            book_hi[book_cnt] = e;
            book_cnt++;
         end
      end
      o.status = st;
      o.accepted = (st == ST_OK);
      return o;
   endfunction

   function automatic req_type make_req(logic [31:0] s, logic [31:0] e);
      req_type r;
      r.range_start = s;
      r.range_end = e;
      return r;
   endfunction

   initial begin
      clock = 0;
      forever #10 clock = ~clock;
   end

   // Note the request beats that the block takes at each rising edge.
   always @(posedge clock) begin
      req_took <= !reset && req_valid && !req_stall;
   end

   // Driver: bursts of beats with random gaps, fed from the pending queue.
   int burst_left;
   int gap_left;
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 0;
         burst_left <= 0;
         gap_left <= 0;
      end else begin
         if (req_took) begin
            queue_rsp(book_interval(req_data));
            void'(pending_reqs.pop_front());
         end
         if (req_valid && !req_took) begin
            // Hold the stalled beat.
         end else if (pause_req || pending_reqs.size() == 0) begin
            req_valid <= 0;
         end else if (gap_left > 0) begin
            gap_left <= gap_left - 1;
            req_valid <= 0;
         end else begin
            req_valid <= 1;
            req_data <= pending_reqs[0];
            if (burst_left == 0) begin
               burst_left <= $urandom_range(1, 8);
               gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 200);
            end else begin
               burst_left <= burst_left - 1;
            end
         end
      end
   end

   // Receiver stall pattern, with a long forced hold when requested.
   always @(negedge clock) begin
      if (reset) begin
         rsp_stall <= 0;
      end else if (hold_cycles > 0) begin
         rsp_stall <= 1;
         hold_cycles <= hold_cycles - 1;
      end else begin
         case ($urandom_range(0, 3))
            0: rsp_stall <= 1;
            1: rsp_stall <= $urandom_range(0, 1);
            default: rsp_stall <= 0;
         endcase
      end
   end

   // Monitor: compare each result beat with the oldest expectation.
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_rsps.size() == 0) begin
            $error("result beat with no expectation: status %0d", rsp_data.status);
            errors++;
         end else begin
            want = expected_rsps.pop_front();
            if (rsp_data.status !== want.status) begin
               $error("status: expected %0d, actual %0d", want.status, rsp_data.status);
               errors++;
            end
            if (rsp_data.accepted !== want.accepted) begin
               $error("accepted: expected %0d, actual %0d", want.accepted,
                      rsp_data.accepted);
               errors++;
            end
         end
      end
   end

   task automatic wait_drained();
      while (pending_reqs.size() != 0 || req_valid) @(posedge clock);
      while (expected_rsps.size() != 0) @(posedge clock);
   endtask

   // Random content for one booking; mostly small windows so overlaps occur.
   task automatic add_random_req(int span);
      logic [31:0] s;
      logic [31:0] e;
      int          k;
      k = $urandom_range(0, 19);
      if (k == 0) begin
         s = $urandom();
         e = $urandom();
      end else if (k == 1) begin
         s = $urandom_range(0, span);
         e = s - $urandom_range(0, 2);
      end else begin
         s = $urandom_range(0, span);
         e = s + $urandom_range(1, span / 4 + 1);
      end
      queue_req(make_req(s, e));
   endtask

   initial begin
      errors = 0;
      book_cnt = 0;
      dbl_cnt = 0;
      hold_cycles = 0;
      pause_req = 0;
      req_data = '0;
      reset = 1;
      repeat (5) @(posedge clock);
      @(negedge clock) reset = 0;

      // Directed: empty ranges, field extremes, doubles and a triple.
      queue_req(make_req(32'd5, 32'd5));
      queue_req(make_req(32'hFFFF_FFFF, 32'd0));
      queue_req(make_req(32'd0, 32'hFFFF_FFFF));
      queue_req(make_req(32'hFFFF_FFFE, 32'hFFFF_FFFF));
      queue_req(make_req(32'd10, 32'd20));
      queue_req(make_req(32'd15, 32'd25));
      queue_req(make_req(32'd20, 32'd21));
      queue_req(make_req(32'd0, 32'd1));
      queue_req(make_req(32'hAAAA_AAAA, 32'hFFFF_FFF0));
      queue_req(make_req(32'h5555_5555, 32'h5555_5556));
      wait_drained();

      // Fill the booking table with disjoint bookings up to table full.
      for (int i = 0; i < 70; i++)
         queue_req(make_req(32'h1000_0000 + i * 4, 32'h1000_0000 + i * 4 + 2));
      // Long receiver hold while the sender keeps offering.
      hold_cycles = 2000;
      wait_drained();

      // Random phases; reset is not reapplied, so tables fill and stay busy
      // mostly with rejections, which still checks the full-table paths.
      for (int i = 0; i < 420; i++) add_random_req(($urandom_range(0, 1)) ? 200 : 60000);
      wait_drained();

      // Sender pause until all results have come, then a last batch.
      pause_req = 1;
      wait_drained();
      pause_req = 0;
      for (int i = 0; i < 20; i++) add_random_req(100);
      wait_drained();
      repeat (300) @(posedge clock);

      if (errors == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

   // Timeout guard.
   initial begin
      #200ms;
      $display("status: fail");
      $finish;
   end
endmodule

@@ interval_booking_double_limit_top.f @@
hw/rtl/ibdl_pkg.sv
hw/rtl/ibdl_cell.sv
hw/rtl/ibdl_ring.sv
hw/rtl/interval_booking_double_limit_top.sv
tb/testbench.sv
